// ===== rtl/gaussian_background_subtractor_macros.svh =====
// Assertion macros for the running Gaussian background subtractor.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef GAUSSIAN_BACKGROUND_SUBTRACTOR_MACROS_SVH
`define GAUSSIAN_BACKGROUND_SUBTRACTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GBS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gbs assertion failed");

// Next-cycle implication, checked outside reset.
`define GBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gbs assertion failed");

`endif

// ===== rtl/gbs_pkg.sv =====
// Shared types, constants and the divider step for the background subtractor.
// No dependencies; imported by every module of the block.
package gbs_pkg;

    // Input beat payload.
    typedef struct packed {
        logic        mode;
        logic [18:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_in_item;

    // Output beat payload.
    typedef struct packed {
        logic       foreground;
        logic [7:0] bg_red;
        logic [7:0] bg_green;
        logic [7:0] bg_blue;
    } t_out_item;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_ALPHA     = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_NOISE     = 2'd2
    } t_reg_idx;

    localparam logic [15:0] ALPHA_RESET     = 16'd3277;
    localparam logic [15:0] THRESHOLD_RESET = 16'd1600;
    localparam logic [15:0] NOISE_RESET     = 16'd12800;

    localparam int NUM_LANES   = 3;
    localparam int DIV_BITS    = 4;
    localparam int QUO_W       = 32;
    localparam int DIV_STAGES  = QUO_W / DIV_BITS;
    localparam int PIPE_DEPTH  = DIV_STAGES + 2;
    // Stages that still hold a model entry that is not yet written back.
    localparam int HAZ_STAGES  = 4;

    // Control shared by all lanes.
    typedef struct packed {
        logic en;
        logic wr_en;
        logic init;
    } t_lane_ctrl;

    // One word of the pipelined divider, with the background byte riding along.
    typedef struct packed {
        logic [16:0]      rem;
        logic [QUO_W-1:0] quo;
        logic [15:0]      dsr;
        logic [7:0]       bg;
    } t_div_word;

    // Several restoring division steps, one quotient bit each.
    function automatic t_div_word div_step(input t_div_word x);
        t_div_word   w;
        logic [16:0] sh;
        w = x;
        for (int k = 0; k < DIV_BITS; k++) begin
            sh = {w.rem[15:0], w.quo[QUO_W-1]};
            if (sh >= {1'b0, w.dsr}) begin
                w.rem = sh - {1'b0, w.dsr};
                w.quo = {w.quo[QUO_W-2:0], 1'b1};
            end else begin
                w.rem = sh;
                w.quo = {w.quo[QUO_W-2:0], 1'b0};
            end
        end
        return w;
    endfunction

endpackage

// ===== rtl/gbs_lane.sv =====
// One color channel: model memory, mean and variance update, pipelined divider.
// Depends on gbs_pkg.
module gbs_lane
    import gbs_pkg::*;
#(
    parameter int DEPTH = 524288,
    parameter int AW    = 19
) (
    input  logic             i_clk,
    input  t_lane_ctrl       i_ctrl,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [7:0]       i_pix,
    input  logic [15:0]      i_alpha,
    input  logic [15:0]      i_noise,
    output logic [QUO_W-1:0] o_quo,
    output logic [7:0]       o_bg
);

    // Model entry: mean in the upper half, variance in the lower half.
    logic [31:0] r_mem [0:DEPTH-1];
    logic [31:0] r_rd;
    logic [31:0] n_word;

    logic [7:0]  r1_s;
    logic [7:0]  r2_s, r3_s, r4_s;
    logic [15:0] r2_mu, r3_mu, r4_mu;
    logic [15:0] r2_var, r3_var, r4_var;
    logic        r2_eneg;
    logic [15:0] r2_ae;
    logic [31:0] r2_e2;
    logic [23:0] r3_q;
    logic        r4_dneg;
    logic [23:0] r4_ad;
    t_div_word   r_div [1:DIV_STAGES];

    logic [15:0] w_mu, w_var;
    logic [16:0] w_e;
    logic [15:0] w_emag;
    logic [31:0] w_e2, w_ae;
    logic [15:0] w_mu_n;
    logic [16:0] w_f;
    logic [15:0] w_fmag;
    logic [31:0] w_ff;
    t_div_word   w_div0;
    logic [24:0] w_d;
    logic [23:0] w_dmag;
    logic [39:0] w_ad;
    logic [24:0] w_nv;
    logic [15:0] w_cap, w_var_n, w_noise1;

    // Memory read on accept, write back at the end of the update path.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_rd <= r_mem[i_rd_addr];
            if (i_ctrl.wr_en) begin
                r_mem[i_wr_addr] <= n_word;
            end
        end
    end

    // Error against the stored mean, its square and the mean step.
    always_comb begin
        w_mu   = r_rd[31:16];
        w_var  = r_rd[15:0];
        w_e    = {1'b0, r1_s, 8'h00} - {1'b0, w_mu};
        w_emag = w_e[16] ? 16'(-w_e) : w_e[15:0];
        w_e2   = 32'(w_emag) * 32'(w_emag);
        w_ae   = 32'(i_alpha) * 32'(w_emag);
    end

    // New mean, error against it, and the divider input.
    always_comb begin
        w_mu_n = r2_eneg ? (r2_mu - r2_ae) : (r2_mu + r2_ae);
        w_f    = {1'b0, r2_s, 8'h00} - {1'b0, w_mu_n};
        w_fmag = w_f[16] ? 16'(-w_f) : w_f[15:0];
        w_ff   = 32'(w_fmag) * 32'(w_fmag);
        w_div0.rem = '0;
        w_div0.quo = r2_e2;
        w_div0.dsr = (r2_var == 16'd0) ? 16'd1 : r2_var;
        w_div0.bg  = w_mu_n[15:8];
    end

    // Variance step toward the new squared error.
    always_comb begin
        w_d    = {1'b0, r3_q} - {9'b0, r3_var};
        w_dmag = w_d[24] ? 24'(-w_d) : w_d[23:0];
        w_ad   = 40'(i_alpha) * 40'(w_dmag);
    end

    // New variance, capped at the noise level and floored at one LSB.
    always_comb begin
        w_nv     = r4_dneg ? ({9'b0, r4_var} - {1'b0, r4_ad})
                           : ({9'b0, r4_var} + {1'b0, r4_ad});
        w_cap    = (w_nv > {9'b0, i_noise}) ? i_noise : w_nv[15:0];
        w_var_n  = (w_cap == 16'd0) ? 16'd1 : w_cap;
        w_noise1 = (i_noise == 16'd0) ? 16'd1 : i_noise;
        n_word   = i_ctrl.init ? {r4_s, 8'h00, w_noise1} : {r4_mu, w_var_n};
    end

    // Pipeline registers of the update path and the divider.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r1_s    <= i_pix;
            r2_s    <= r1_s;
            r2_mu   <= w_mu;
            r2_var  <= w_var;
            r2_eneg <= w_e[16];
            r2_ae   <= w_ae[31:16];
            r2_e2   <= w_e2;
            r3_s    <= r2_s;
            r3_mu   <= w_mu_n;
            r3_var  <= r2_var;
            r3_q    <= w_ff[31:8];
            r4_s    <= r3_s;
            r4_mu   <= r3_mu;
            r4_var  <= r3_var;
            r4_dneg <= w_d[24];
            r4_ad   <= w_ad[39:16];
            r_div[1] <= div_step(w_div0);
            for (int k = 2; k <= DIV_STAGES; k++) begin
                r_div[k] <= div_step(r_div[k-1]);
            end
        end
    end

    assign o_quo = r_div[DIV_STAGES].quo;
    assign o_bg  = r_div[DIV_STAGES].bg;

endmodule

// ===== rtl/gbs_merge.sv =====
// Merge stage: sums the lanes' normalized distances, applies the threshold,
// and holds the output beat. Depends on gbs_pkg.
module gbs_merge
    import gbs_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic                             i_ready,
    input  logic [NUM_LANES-1:0][QUO_W-1:0]  i_quo,
    input  logic [NUM_LANES-1:0][7:0]        i_bg,
    input  logic [15:0]                      i_threshold,
    output logic                             o_valid,
    output t_out_item                        o_out
);

    logic        r_valid;
    t_out_item   r_out;
    logic [33:0] w_sum;

    // Distance summed over the channels, kept wide.
    assign w_sum = 34'(i_quo[0]) + 34'(i_quo[1]) + 34'(i_quo[2]);

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out.foreground <= (w_sum >= 34'(i_threshold));
            r_out.bg_red     <= i_bg[0];
            r_out.bg_green   <= i_bg[1];
            r_out.bg_blue    <= i_bg[2];
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

// ===== rtl/gaussian_background_subtractor.sv =====
// Running Gaussian background subtractor. One pixel beat is taken per clock unless
// the output stalls or a pending entry holds it; an update beat gives a result, an
// init beat gives none. The per-pixel model sits in one memory per color channel
// and is read on accept and written back at the end of the update path, so a beat
// whose pixel index matches one of the four beats still in that read-modify-write
// window waits until the entry is written. The memory has no reset and needs no
// clearing pass: a pixel must be initialized before it is updated.
`include "gaussian_background_subtractor_macros.svh"

module gaussian_background_subtractor
    import gbs_pkg::*;
#(
    parameter int FRAME_PIXELS = 524288
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_in,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int IW = AW + 19;

    logic [15:0] r_alpha, r_threshold, r_noise;
    logic        r_vld  [1:PIPE_DEPTH];
    logic        r_upd  [1:PIPE_DEPTH];
    logic [AW-1:0] r_addr [1:HAZ_STAGES];

    logic [IW-1:0] w_idx_wide;
    logic [AW-1:0] w_addr;
    logic          w_in_range, w_hazard, w_en, w_accept, w_last_res;
    t_lane_ctrl    w_ctrl;
    logic [NUM_LANES-1:0][7:0]       w_pix;
    logic [NUM_LANES-1:0][QUO_W-1:0] w_quo;
    logic [NUM_LANES-1:0][7:0]       w_bg;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RESET;
            r_threshold <= THRESHOLD_RESET;
            r_noise     <= NOISE_RESET;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_ALPHA:     r_alpha     <= pwdata[15:0];
                REG_THRESHOLD: r_threshold <= pwdata[15:0];
                REG_NOISE:     r_noise     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Configuration reads.
    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_ALPHA:     prdata = {16'b0, r_alpha};
            REG_THRESHOLD: prdata = {16'b0, r_threshold};
            REG_NOISE:     prdata = {16'b0, r_noise};
            default:       prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Address, range check and read-after-write hazard against pending entries.
    always_comb begin
        w_idx_wide = IW'(i_in.pixel_index);
        w_in_range = (w_idx_wide < IW'(FRAME_PIXELS));
        w_addr     = w_idx_wide[AW-1:0];
        w_hazard   = 1'b0;
        for (int k = 1; k <= HAZ_STAGES; k++) begin
            if (r_vld[k] && (r_addr[k] == w_addr)) begin
                w_hazard = 1'b1;
            end
        end
    end

    // The pipeline moves unless a result waits on a full output register.
    assign w_last_res = r_vld[PIPE_DEPTH] && r_upd[PIPE_DEPTH];
    assign w_en       = !(o_valid && !i_ready && w_last_res);
    assign o_ready    = w_en && !w_hazard;
    assign w_accept   = i_valid && o_ready;

    // Beat tracking along the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= PIPE_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
                r_upd[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[1] <= w_accept && w_in_range;
            r_upd[1] <= !i_in.mode;
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
                r_upd[k] <= r_upd[k-1];
            end
        end
    end

    // Addresses of entries not yet written back.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_addr[1] <= w_addr;
            for (int k = 2; k <= HAZ_STAGES; k++) begin
                r_addr[k] <= r_addr[k-1];
            end
        end
    end

    assign w_ctrl.en    = w_en;
    assign w_ctrl.wr_en = r_vld[HAZ_STAGES];
    assign w_ctrl.init  = !r_upd[HAZ_STAGES];

    assign w_pix[0] = i_in.red;
    assign w_pix[1] = i_in.green;
    assign w_pix[2] = i_in.blue;

    // One lane per color channel.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        gbs_lane #(
            .DEPTH (FRAME_PIXELS),
            .AW    (AW)
        ) u_lane (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_rd_addr (w_addr),
            .i_wr_addr (r_addr[HAZ_STAGES]),
            .i_pix     (w_pix[g]),
            .i_alpha   (r_alpha),
            .i_noise   (r_noise),
            .o_quo     (w_quo[g]),
            .o_bg      (w_bg[g])
        );
    end

    // Threshold and output register.
    gbs_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_en && w_last_res),
        .i_ready     (i_ready),
        .i_quo       (w_quo),
        .i_bg        (w_bg),
        .i_threshold (r_threshold),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

    // A new read never meets the write of the same entry.
    `GBS_ASSERT_IMPL(a_no_rw_clash, w_accept && w_in_range && r_vld[HAZ_STAGES], w_addr != r_addr[HAZ_STAGES])
    // A result leaving the pipeline shows up at the output.
    `GBS_ASSERT_NEXT(a_result_shown, w_en && w_last_res, o_valid)
    // An init beat leaving the pipeline gives no result.
    `GBS_ASSERT_NEXT(a_init_silent, w_en && r_vld[PIPE_DEPTH] && !r_upd[PIPE_DEPTH] && (!o_valid || i_ready), !o_valid)

endmodule

// ===== sim/gbs_model_checker.sv =====
// Checker for the background subtractor: watches the pixel, result and APB channels,
// predicts each update beat from its own copy of the per-pixel model and compares.
// Depends on gbs_pkg for the beat payload types and the register indexes.
module gbs_model_checker
    import gbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);

    // Predicted configuration and per-pixel model (Q8.8 per channel).
    logic [15:0] learn_rate;
    logic [15:0] fg_threshold;
    logic [15:0] noise_level;
    logic [15:0] mean_mem [bit [18:0]][3];
    logic [15:0] var_mem  [bit [18:0]][3];

    // Results still owed by the block, oldest first.
    t_out_item expected_results [$];

    // (alpha * x) >> 16 with truncation toward zero.
    function automatic longint scale_rate(input longint x);
        longint mag;
        longint p;
        mag = (x < 0) ? -x : x;
        p = (longint'(learn_rate) * mag) >>> 16;
        return (x < 0) ? -p : p;
    endfunction

    // Apply one accepted pixel beat to the model; queue a result for updates.
    task automatic model_pixel(input t_in_item it);
        logic [7:0] pix [3];
        t_out_item  res;
        longint     s, mu, vr, dv, e, f, q, d, nv;
        longint     dist_sum;
        pix[0] = it.red;
        pix[1] = it.green;
        pix[2] = it.blue;
        dist_sum = 0;
        if (it.mode) begin
            for (int c = 0; c < 3; c++) begin
                mean_mem[it.pixel_index][c] = {pix[c], 8'h00};
                var_mem[it.pixel_index][c] = (noise_level == 0) ? 16'd1 : noise_level;
            end
        end else begin
            if (!mean_mem.exists(it.pixel_index)) begin
                for (int c = 0; c < 3; c++) begin
                    mean_mem[it.pixel_index][c] = '0;
                    var_mem[it.pixel_index][c] = '0;
                end
            end
            res.foreground = 1'b0;
            for (int c = 0; c < 3; c++) begin
                s  = longint'(pix[c]) * 256;
                mu = longint'(mean_mem[it.pixel_index][c]);
                vr = longint'(var_mem[it.pixel_index][c]);
                dv = (vr == 0) ? 1 : vr;
                e  = s - mu;
                dist_sum += (e * e) / dv;
                mu += scale_rate(e);
                if (mu < 0) mu = 0;
                if (mu > 65535) mu = 65535;
                f  = s - mu;
                q  = (f * f) >>> 8;
                d  = q - vr;
                nv = vr + scale_rate(d);
                if (nv > longint'(noise_level)) nv = longint'(noise_level);
                if (nv < 1) nv = 1;
                mean_mem[it.pixel_index][c] = mu[15:0];
                var_mem[it.pixel_index][c] = nv[15:0];
                case (c)
                    0: res.bg_red = mu[15:8];
                    1: res.bg_green = mu[15:8];
                    default: res.bg_blue = mu[15:8];
                endcase
            end
            res.foreground = (dist_sum >= longint'(fg_threshold));
            expected_results.push_back(res);
        end
    endtask

    // Watch every channel at each edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            learn_rate <= ALPHA_RESET;
            fg_threshold <= THRESHOLD_RESET;
            noise_level <= NOISE_RESET;
        end else begin
            // Register writes must come only while the block is idle; nothing here enforces it.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_ALPHA:     learn_rate <= i_pwdata[15:0];
                    REG_THRESHOLD: fg_threshold <= i_pwdata[15:0];
                    REG_NOISE:     noise_level <= i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                model_pixel(i_in);
            end
            // Compare each result beat with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("Unexpected result beat %h", i_out);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (want.foreground !== i_out.foreground || want.bg_red !== i_out.bg_red ||
                        want.bg_green !== i_out.bg_green || want.bg_blue !== i_out.bg_blue)
                    begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("Mismatch: expected fg=%0d bg=%0d,%0d,%0d got fg=%0d bg=%0d,%0d,%0d",
                                     want.foreground, want.bg_red, want.bg_green, want.bg_blue,
                                     i_out.foreground, i_out.bg_red, i_out.bg_green,
                                     i_out.bg_blue);
                        end
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

endmodule

// ===== sim/tb_gaussian_background_subtractor.sv =====
// Testbench top for the background subtractor: drives pixel beats, result stalls and
// APB register writes through several settings, and gives the verdict.
// Depends on gbs_pkg, the block, and gbs_model_checker.
module tb_gaussian_background_subtractor;
    import gbs_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int POOL_SIZE = 48;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_in;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          quiet_cycles;

    // Pixels whose model has been loaded, and a small pool to revisit often.
    bit          loaded [bit [18:0]];
    logic [18:0] pixel_pool [POOL_SIZE];

    gaussian_background_subtractor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_in(i_in),
        .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gbs_model_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_in(i_in),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out(o_out),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(15, 45);
    endfunction

    // Result side: alternate ready and stall stretches of random length.
    int ready_hold;
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (i_ready) begin
            i_ready <= 1'b0;
            ready_hold <= pick_gap();
        end else begin
            i_ready <= 1'b1;
            ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 12);
        end
    end

    // Watchdog on cycles with no beat on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Send one pixel beat after an optional gap; returns once it is accepted.
    task automatic send_pixel(input logic mode, input logic [18:0] idx,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= '{mode: mode, pixel_index: idx, red: r, green: g, blue: b};
        do @(posedge i_clk); while (!o_ready);
        if (mode) loaded[idx] = 1'b1;
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(input t_reg_idx which, input logic [15:0] value);
        i_valid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait for all results, then let init beats drain through the pipeline.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 6) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] a, input logic [15:0] t,
                              input logic [15:0] n);
        drain();
        write_reg(REG_ALPHA, a);
        write_reg(REG_THRESHOLD, t);
        write_reg(REG_NOISE, n);
    endtask

    // One phase of random traffic over the pool, mostly updates of loaded pixels.
    task automatic random_phase(input int count);
        logic [18:0] idx;
        for (int k = 0; k < POOL_SIZE; k++) begin
            send_pixel(1'b1, pixel_pool[k], 8'($urandom), 8'($urandom), 8'($urandom));
        end
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                // Occasional pixel anywhere in the frame, loaded then updated.
                idx = 19'($urandom);
                send_pixel(1'b1, idx, 8'($urandom), 8'($urandom), 8'($urandom));
                send_pixel(1'b0, idx, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                idx = pixel_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_pixel(($urandom_range(0, 5) == 0), idx,
                           8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in = '0;
        i_ready = 1'b0;
        ready_hold = 0;
        quiet_cycles = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pixel_pool[0] = 19'h00000;
        pixel_pool[1] = 19'h7FFFF;
        pixel_pool[2] = 19'h2AAAA;
        pixel_pool[3] = 19'h55555;
        for (int k = 4; k < POOL_SIZE; k++) pixel_pool[k] = 19'($urandom);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, extreme pixels and indexes, repeated hits.
        send_pixel(1'b1, 19'h00000, 8'd0, 8'd0, 8'd0);
        send_pixel(1'b1, 19'h7FFFF, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 19'h00000, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 19'h00000, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 19'h7FFFF, 8'd0, 8'd0, 8'd0);
        send_pixel(1'b0, 19'h7FFFF, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 19'h00000, 8'd0, 8'd128, 8'd255);
        send_pixel(1'b1, 19'h2AAAA, 8'd100, 8'd100, 8'd100);
        send_pixel(1'b0, 19'h2AAAA, 8'd100, 8'd100, 8'd100);
        send_pixel(1'b0, 19'h2AAAA, 8'd101, 8'd99, 8'd100);

        // Full learning rate and zero threshold.
        set_config(16'hFFFF, 16'h0000, 16'hFFFF);
        send_pixel(1'b0, 19'h00000, 8'd200, 8'd10, 8'd0);
        send_pixel(1'b0, 19'h00000, 8'd200, 8'd10, 8'd0);
        send_pixel(1'b1, 19'h55555, 8'd0, 8'd255, 8'd0);
        send_pixel(1'b0, 19'h55555, 8'd255, 8'd0, 8'd255);

        // Frozen model, smallest nonzero noise level, largest threshold.
        set_config(16'h0000, 16'hFFFF, 16'h0001);
        send_pixel(1'b1, 19'h55555, 8'd7, 8'd8, 8'd9);
        send_pixel(1'b0, 19'h55555, 8'd255, 8'd0, 8'd255);
        send_pixel(1'b0, 19'h7FFFF, 8'd0, 8'd0, 8'd0);

        // Zero noise level.
        set_config(16'h8000, 16'h0100, 16'h0000);
        send_pixel(1'b1, 19'h00000, 8'd50, 8'd60, 8'd70);
        send_pixel(1'b0, 19'h00000, 8'd51, 8'd0, 8'd255);
        send_pixel(1'b0, 19'h00000, 8'd50, 8'd60, 8'd70);

        // Random phases through several settings.
        set_config(ALPHA_RESET, THRESHOLD_RESET, NOISE_RESET);
        random_phase(200);
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(180);
        set_config(16'h0000, 16'h0000, 16'h0001);
        random_phase(180);
        set_config(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
        random_phase(180);
        set_config(16'($urandom), 16'($urandom_range(0, 4000)),
                   16'($urandom_range(256, 20000)));
        random_phase(180);

        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
